@@ rtl/core/greedy_max_degree_vertex_cover_assert.svh @@
// Assertion macros for the greedy vertex cover core.
// Expects signals named clk and rst in the scope of each use.
`ifndef GREEDY_MAX_DEGREE_VERTEX_COVER_ASSERT_SVH
`define GREEDY_MAX_DEGREE_VERTEX_COVER_ASSERT_SVH

// same-cycle implication
`define GMDVC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMDVC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gmdvc_pkg.sv @@
// Shared types and codes for the greedy vertex cover core.
// No dependencies.
package gmdvc_pkg;

  localparam int FIELD_W = 7;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [FIELD_W-1:0] VCOUNT_RESET = 7'd64;

  typedef logic [1:0] alu_op_t;

  localparam alu_op_t ALU_CMP = 2'd0;
  localparam alu_op_t ALU_INC = 2'd1;
  localparam alu_op_t ALU_DEC = 2'd2;

endpackage

@@ rtl/core/greedy_max_degree_vertex_cover.sv @@
// Greedy max-degree vertex cover engine, top level.
// Depends on gmdvc_pkg, gmdvc_vtable, gmdvc_alu and the assertion macro header.
//
//   channel  | signals                                         | dir
//   ---------+-------------------------------------------------+-----
//   config   | cfg_write, cfg_data (vertex_count)              | in
//   request  | in_valid, in_ready, cmd, first_vertex,          | in
//            | second_vertex                                   |
//   result   | out_valid, out_ready, cover_vertex,             | out
//            | removed_degree, done_res                        |
//
// Add edge: read row, write row, optional read/write of the mirror row.
// Pick: a degree scan over the first n vertices, n being vertex_count capped at
// MAX_VERTICES, then a neighbor walk over all MAX_VERTICES rows; both go one vertex
// a cycle through the single vertex table read port. A pick that finds no edge left
// ends after the scan, and one with n zero skips the scan.
// Reset and the clear command run a clearing pass over every word of the vertex
// table; no request is taken meanwhile (config writes still land).
// Results sit in an output register; a new request is taken while one waits there.
// A pick whose result finds the output register still full holds until it drains.
`include "greedy_max_degree_vertex_cover_assert.svh"

module greedy_max_degree_vertex_cover #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gmdvc_pkg::FIELD_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gmdvc_pkg::CMD_W-1:0]     cmd,
  input  logic [gmdvc_pkg::FIELD_W-1:0]   first_vertex,
  input  logic [gmdvc_pkg::FIELD_W-1:0]   second_vertex,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gmdvc_pkg::FIELD_W-1:0]   cover_vertex,
  output logic [gmdvc_pkg::FIELD_W-1:0]   removed_degree,
  output logic                            done_res
);
  import gmdvc_pkg::*;

  localparam int VW     = $clog2(MAX_VERTICES);      // vertex index
  localparam int CW     = $clog2(MAX_VERTICES + 1);  // counts up to MAX_VERTICES
  localparam int DW     = CW;                        // degree
  localparam int WORD_W = MAX_VERTICES + DW;
  localparam int CMPW   = (CW > FIELD_W) ? CW : FIELD_W;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD_U  = 4'd2;
  localparam logic [3:0] ST_ADD_V  = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_ROW    = 4'd5;
  localparam logic [3:0] ST_WALK   = 4'd6;
  localparam logic [3:0] ST_ZERO   = 4'd7;
  localparam logic [3:0] ST_RESULT = 4'd8;

  // control registers
  logic [3:0]              state, state_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic                    rd_pend, rd_pend_next;
  logic [MAX_VERTICES-1:0] covered, covered_next;
  logic [FIELD_W-1:0]      vcount;
  logic                    out_valid_r, out_valid_next;

  // payload registers
  logic [VW-1:0]           rd_idx, rd_idx_next;
  logic [VW-1:0]           best_idx, best_idx_next;
  logic [DW-1:0]           best_deg, best_deg_next;
  logic [MAX_VERTICES-1:0] row_reg, row_next;
  logic [VW-1:0]           u_idx, u_next;
  logic [VW-1:0]           v_idx, v_next;
  logic [FIELD_W-1:0]      cover_r, cover_next;
  logic [FIELD_W-1:0]      removed_r, removed_next;
  logic                    done_r, done_next;

  // vertex table port
  logic                    mem_we, mem_re;
  logic [VW-1:0]           mem_waddr, mem_raddr;
  logic [WORD_W-1:0]       mem_wdata, rd_data;
  logic [MAX_VERTICES-1:0] rd_row;
  logic [DW-1:0]           rd_deg;

  // shared degree unit
  alu_op_t                 alu_op;
  logic [DW-1:0]           alu_y;
  logic                    alu_gt;

  // request decode
  logic [CMPW-1:0]         vcount_ext;
  logic [CW-1:0]           n_eff;
  logic                    a_ok, b_ok;
  logic [FIELD_W-1:0]      a_m1, b_m1;
  logic [VW-1:0]           a_idx, b_idx;
  logic [MAX_VERTICES-1:0] mask_u, mask_v, mask_best;
  logic [VW:0]             best_num;

  gmdvc_vtable #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (WORD_W)
  ) u_vtable (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  gmdvc_alu #(
    .DW (DW)
  ) u_alu (
    .op (alu_op),
    .a  (rd_deg),
    .b  (best_deg),
    .y  (alu_y),
    .gt (alu_gt)
  );

  assign rd_row = rd_data[MAX_VERTICES-1:0];
  assign rd_deg = rd_data[WORD_W-1:MAX_VERTICES];

  // register value saturates at the table size
  assign vcount_ext = CMPW'(vcount);
  assign n_eff = (vcount_ext > CMPW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount);

  assign a_ok  = (first_vertex != '0) && (CMPW'(first_vertex) <= CMPW'(n_eff));
  assign b_ok  = (second_vertex != '0) && (CMPW'(second_vertex) <= CMPW'(n_eff));
  assign a_m1  = first_vertex - FIELD_W'(1);
  assign b_m1  = second_vertex - FIELD_W'(1);
  assign a_idx = VW'(a_m1);
  assign b_idx = VW'(b_m1);

  assign mask_u    = MAX_VERTICES'(1) << u_idx;
  assign mask_v    = MAX_VERTICES'(1) << v_idx;
  assign mask_best = MAX_VERTICES'(1) << best_idx;
  assign best_num  = {1'b0, best_idx} + (VW+1)'(1);

  assign in_ready       = (state == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign cover_vertex   = cover_r;
  assign removed_degree = removed_r;
  assign done_res       = done_r;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    rd_pend_next   = rd_pend;
    rd_idx_next    = rd_idx;
    covered_next   = covered;
    best_idx_next  = best_idx;
    best_deg_next  = best_deg;
    row_next       = row_reg;
    u_next         = u_idx;
    v_next         = v_idx;
    out_valid_next = out_valid_r && !out_ready;
    cover_next     = cover_r;
    removed_next   = removed_r;
    done_next      = done_r;
    mem_we         = 1'b0;
    mem_waddr      = rd_idx;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = cnt[VW-1:0];
    alu_op         = ALU_CMP;

    case (state)
      ST_CLEAR: begin
        // zero one table word a cycle
        mem_we    = 1'b1;
        mem_waddr = cnt[VW-1:0];
        mem_wdata = '0;
        if (cnt == CW'(MAX_VERTICES - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_ADD: begin
              if (a_ok && b_ok) begin
                u_next     = a_idx;
                v_next     = b_idx;
                mem_re     = 1'b1;
                mem_raddr  = a_idx;
                state_next = ST_ADD_U;
              end
            end
            CMD_PICK: begin
              best_deg_next = '0;
              best_idx_next = '0;
              cnt_next      = '0;
              rd_pend_next  = 1'b0;
              state_next    = (n_eff == '0) ? ST_RESULT : ST_SCAN;
            end
            CMD_CLEAR: begin
              covered_next = '0;
              cnt_next     = '0;
              state_next   = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ADD_U: begin
        // repeated edge leaves everything alone; rows are kept symmetric
        alu_op = ALU_INC;
        if (!rd_row[v_idx]) begin
          mem_we    = 1'b1;
          mem_waddr = u_idx;
          mem_wdata = {alu_y, rd_row | mask_v};
          if (u_idx != v_idx) begin
            mem_re     = 1'b1;
            mem_raddr  = v_idx;
            state_next = ST_ADD_V;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_ADD_V: begin
        alu_op     = ALU_INC;
        mem_we     = 1'b1;
        mem_waddr  = v_idx;
        mem_wdata  = {alu_y, rd_row | mask_u};
        state_next = ST_IDLE;
      end

      ST_SCAN: begin
        // read vertex cnt while comparing the one read last cycle
        alu_op = ALU_CMP;
        if (cnt != n_eff) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt[VW-1:0];
          rd_idx_next  = cnt[VW-1:0];
          cnt_next     = cnt + CW'(1);
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
        end
        if (rd_pend && alu_gt && !covered[rd_idx]) begin
          best_deg_next = rd_deg;
          best_idx_next = rd_idx;
        end
        if (rd_pend && (cnt == n_eff)) begin
          if (best_deg_next == '0) begin
            state_next = ST_RESULT;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = best_idx_next;
            state_next = ST_ROW;
          end
        end
      end

      ST_ROW: begin
        row_next               = rd_row;
        covered_next[best_idx] = 1'b1;
        cnt_next               = '0;
        rd_pend_next           = 1'b0;
        state_next             = ST_WALK;
      end

      ST_WALK: begin
        // read every row and rewrite each neighbor row, one vertex a cycle
        alu_op = ALU_DEC;
        if (cnt != CW'(MAX_VERTICES)) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt[VW-1:0];
          rd_idx_next  = cnt[VW-1:0];
          cnt_next     = cnt + CW'(1);
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
        end
        if (rd_pend && row_reg[rd_idx]) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx;
          mem_wdata = {alu_y, rd_row & ~mask_best};
        end
        if (rd_pend && (cnt == CW'(MAX_VERTICES))) begin
          state_next = ST_ZERO;
        end
      end

      ST_ZERO: begin
        mem_we     = 1'b1;
        mem_waddr  = best_idx;
        mem_wdata  = '0;
        state_next = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_next = 1'b1;
          cover_next     = (best_deg == '0) ? '0 : FIELD_W'(best_num);
          removed_next   = FIELD_W'(best_deg);
          done_next      = (best_deg == '0);
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      rd_pend     <= 1'b0;
      covered     <= '0;
      vcount      <= VCOUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      rd_pend     <= rd_pend_next;
      covered     <= covered_next;
      out_valid_r <= out_valid_next;
      if (cfg_write) begin
        vcount <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx    <= rd_idx_next;
    best_idx  <= best_idx_next;
    best_deg  <= best_deg_next;
    row_reg   <= row_next;
    u_idx     <= u_next;
    v_idx     <= v_next;
    cover_r   <= cover_next;
    removed_r <= removed_next;
    done_r    <= done_next;
  end

  `GMDVC_ASSERT_IMP(a_result_from_pick, $rose(out_valid), $past(state) == ST_RESULT, "result without pick")
  `GMDVC_ASSERT_IMP(a_done_is_empty, out_valid && done_res, cover_vertex == '0 && removed_degree == '0, "done with vertex")
  `GMDVC_ASSERT_NXT(a_pick_busy, in_valid && in_ready && cmd == CMD_PICK, !in_ready, "pick did not start")
  `GMDVC_ASSERT_IMP(a_port_split, mem_we && mem_re, mem_waddr != mem_raddr, "read and write same word")

endmodule

@@ rtl/core/gmdvc_vtable.sv @@
// Vertex table memory: one word per vertex, {degree, adjacency row}.
// One write port, one registered read port. Uses no package.
module gmdvc_vtable #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 71
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/gmdvc_alu.sv @@
// Shared degree unit: compare against running best, increment, saturating decrement.
// Depends on gmdvc_pkg for the operation codes.
module gmdvc_alu #(
  parameter int DW = 7
) (
  input  gmdvc_pkg::alu_op_t op,
  input  logic [DW-1:0]      a,
  input  logic [DW-1:0]      b,
  output logic [DW-1:0]      y,
  output logic               gt
);
  import gmdvc_pkg::*;

  always_comb begin
    case (op)
      ALU_INC: y = a + DW'(1);
      ALU_DEC: y = (a == '0) ? '0 : a - DW'(1);
      ALU_CMP: y = a;
      default: y = a;
    endcase
  end

  assign gt = (a > b);

endmodule
